// ===== rtl/cudp_pkg.sv =====
// Shared types, constants and control-word layout for the decay-usage priority unit.
package cudp_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int FSCALE       = 1 << FRAC_BITS;
    localparam int CPU_W        = 8;
    localparam int TICKS_W      = 10;
    localparam int TSC_STEPS    = TICKS_W + FRAC_BITS;
    localparam int DEC_STEPS    = CPU_W;
    localparam int RSS_PENALTY  = 2 * 4;
    localparam int PRIO_MAX     = 127;
    localparam int PRIO_MIN     = 1;
    localparam int PCT_MAX      = 511;
    localparam int CPU_MAX      = 255;
    localparam int TIME_MAX     = 127;
    localparam int PC_W         = 5;
    localparam int CNT_W        = 5;

    // register map, word index
    typedef enum logic [2:0] {
        REG_LOAD_AVG   = 3'd0,
        REG_LOAD_MUL   = 3'd1,
        REG_PCT_DECAY  = 3'd2,
        REG_TICKS_PS   = 3'd3,
        REG_FAV_BIAS   = 3'd4,
        REG_NICE_ZERO  = 3'd5,
        REG_USER_BASE  = 3'd6
    } reg_idx_t;

    localparam logic CMD_PERIODIC = 1'b0;
    localparam logic CMD_WAKE     = 1'b1;

    typedef struct packed {
        logic [15:0] load_average;
        logic [3:0]  load_multiplier;
        logic [8:0]  percent_decay;
        logic [9:0]  ticks_per_second;
        logic [5:0]  favored_bias;
        logic [5:0]  nice_zero;
        logic [6:0]  user_base_priority;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  cpu_usage;
        logic [9:0]  cpu_ticks;
        logic [8:0]  pct_cpu;
        logic [5:0]  nice_value;
        logic [6:0]  run_time;
        logic [6:0]  sleep_time;
        logic        asleep_or_stopped;
        logic        favored;
        logic        over_rss_limit;
        logic        memory_short;
        logic [6:0]  current_priority;
    } item_t;

    typedef struct packed {
        logic [7:0]  new_cpu_usage;
        logic [8:0]  new_pct_cpu;
        logic [6:0]  user_priority;
        logic        priority_valid;
        logic [6:0]  new_run_time;
        logic [6:0]  new_sleep_time;
        logic        reschedule;
    } res_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP       = 5'd0,
        OP_MUL_B     = 5'd1,
        OP_TIMES     = 5'd2,
        OP_MUL_PD    = 5'd3,
        OP_TSC_LOAD  = 5'd4,
        OP_DIV_STEP  = 5'd5,
        OP_MUL_FOLD  = 5'd6,
        OP_ACC_ADD   = 5'd7,
        OP_PCT_MULCB = 5'd8,
        OP_DEC_LOAD  = 5'd9,
        OP_CPU_BIAS  = 5'd10,
        OP_PRIO      = 5'd11,
        OP_PCT_LONG  = 5'd12,
        OP_WAKE_INIT = 5'd13,
        OP_MUL_CB    = 5'd14,
        OP_WAKE_NEXT = 5'd15,
        OP_WAKE_CPU  = 5'd16
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        JC_NONE   = 3'd0,
        JC_ALWAYS = 3'd1,
        JC_WAKE   = 3'd2,
        JC_LONG   = 3'd3,
        JC_SHORT  = 3'd4,
        JC_WDONE  = 3'd5,
        JC_LOOP   = 3'd6
    } jc_t;

    typedef struct packed {
        logic wake;
        logic long_sleep;
        logic wake_short;
        logic wake_done;
    } flags_t;

    typedef struct packed {
        op_t             op;
        jc_t             jc;
        logic [PC_W-1:0] tgt;
        logic            cnt_ld;
        logic [CNT_W-1:0] cnt_val;
        logic            fin;
    } uword_t;

endpackage

// ===== rtl/cpu_usage_decay_priority.sv =====
// Top level of the decay-usage scheduler priority unit: config registers, handshakes.
//
// Usage:
//   One process record enters per request on the s_ channel (valid/ready);
//   one result record leaves per request on the m_ channel (valid/ready).
//   Configuration registers sit on an APB-style port, one 32-bit word each
//   at byte address 4*index; pready is tied high, reads return the value.
//   The user must write registers only while the block is idle; the block itself does not enforce it.
// Paths through the microcode program, from accept to m_valid:
//   periodic, long sleeper
//   periodic, normal (18-step tick divide, 8-step decay)
//   wake, sleep time 0 or 1
//   wake, n = sleep_time - 2 decays when usage stays nonzero
//     (each decay is one multiply and an 8-step divide on the shared divider)
// Flow: one request in flight; s_ready returns the cycle after the result
//   moves into the output register, so a new request is taken while a finished
//   result still waits. If the receiver stalls with a full output register, the
//   sequencer holds on its last step until the slot frees.
// Reset (aresetn, synchronous, active low): registers to their defaults,
//   sequencer idle, output register empty.
module cpu_usage_decay_priority (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_cpu_usage,
    input  logic [9:0]  s_cpu_ticks,
    input  logic [8:0]  s_pct_cpu,
    input  logic [5:0]  s_nice_value,
    input  logic [6:0]  s_run_time,
    input  logic [6:0]  s_sleep_time,
    input  logic        s_asleep_or_stopped,
    input  logic        s_favored,
    input  logic        s_over_rss_limit,
    input  logic        s_memory_short,
    input  logic [6:0]  s_current_priority,
    // result out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_new_cpu_usage,
    output logic [8:0]  m_new_pct_cpu,
    output logic [6:0]  m_user_priority,
    output logic        m_priority_valid,
    output logic [6:0]  m_new_run_time,
    output logic [6:0]  m_new_sleep_time,
    output logic        m_reschedule
);
    import cudp_pkg::*;

    cfg_t     cfg_reg;
    res_t     out_reg;
    logic     m_valid_reg;
    item_t    item;
    res_t     res;
    flags_t   flags;
    op_t      op;
    logic     done;
    logic     busy;
    logic     start;
    logic     out_free;
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.load_average       <= 16'd0;
            cfg_reg.load_multiplier    <= 4'd2;
            cfg_reg.percent_decay      <= 9'd243;
            cfg_reg.ticks_per_second   <= 10'd100;
            cfg_reg.favored_bias       <= 6'(-10);
            cfg_reg.nice_zero          <= 6'd20;
            cfg_reg.user_base_priority <= 7'd50;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LOAD_AVG:  cfg_reg.load_average       <= pwdata[15:0];
                REG_LOAD_MUL:  cfg_reg.load_multiplier    <= pwdata[3:0];
                REG_PCT_DECAY: cfg_reg.percent_decay      <= pwdata[8:0];
                REG_TICKS_PS:  cfg_reg.ticks_per_second   <= pwdata[9:0];
                REG_FAV_BIAS:  cfg_reg.favored_bias       <= pwdata[5:0];
                REG_NICE_ZERO: cfg_reg.nice_zero          <= pwdata[5:0];
                REG_USER_BASE: cfg_reg.user_base_priority <= pwdata[6:0];
                default: ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LOAD_AVG:  prdata = 32'(cfg_reg.load_average);
            REG_LOAD_MUL:  prdata = 32'(cfg_reg.load_multiplier);
            REG_PCT_DECAY: prdata = 32'(cfg_reg.percent_decay);
            REG_TICKS_PS:  prdata = 32'(cfg_reg.ticks_per_second);
            REG_FAV_BIAS:  prdata = {{26{cfg_reg.favored_bias[5]}}, cfg_reg.favored_bias};
            REG_NICE_ZERO: prdata = 32'(cfg_reg.nice_zero);
            REG_USER_BASE: prdata = 32'(cfg_reg.user_base_priority);
            default:       prdata = '0;
        endcase
    end

    // ---------------- request capture ----------------
    assign s_ready = !busy;
    assign start   = s_valid && s_ready;

    assign item.command           = s_command;
    assign item.cpu_usage         = s_cpu_usage;
    assign item.cpu_ticks         = s_cpu_ticks;
    assign item.pct_cpu           = s_pct_cpu;
    assign item.nice_value        = s_nice_value;
    assign item.run_time          = s_run_time;
    assign item.sleep_time        = s_sleep_time;
    assign item.asleep_or_stopped = s_asleep_or_stopped;
    assign item.favored           = s_favored;
    assign item.over_rss_limit    = s_over_rss_limit;
    assign item.memory_short      = s_memory_short;
    assign item.current_priority  = s_current_priority;

    // ---------------- sequencer and datapath ----------------
    // The sequencer only leaves its final step when the output slot is free.
    assign out_free = !m_valid_reg || m_ready;

    cudp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .flags    (flags),
        .op       (op),
        .done     (done),
        .busy     (busy)
    );

    cudp_dp u_dp (
        .aclk  (aclk),
        .load  (start),
        .item  (item),
        .cfg   (cfg_reg),
        .op    (op),
        .flags (flags),
        .res   (res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_new_cpu_usage  = out_reg.new_cpu_usage;
    assign m_new_pct_cpu    = out_reg.new_pct_cpu;
    assign m_user_priority  = out_reg.user_priority;
    assign m_priority_valid = out_reg.priority_valid;
    assign m_new_run_time   = out_reg.new_run_time;
    assign m_new_sleep_time = out_reg.new_sleep_time;
    assign m_reschedule     = out_reg.reschedule;

endmodule

// ===== rtl/cudp_seq.sv =====
// Microcode sequencer: program ROM, step counter, loop counter and jump logic.
module cudp_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             out_free,
    input  cudp_pkg::flags_t flags,
    output cudp_pkg::op_t    op,
    output logic             done,
    output logic             busy
);
    import cudp_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    localparam logic [PC_W-1:0] S_DIV_TSC = PC_W'(4);
    localparam logic [PC_W-1:0] S_DIV_CPU = PC_W'(9);
    localparam logic [PC_W-1:0] S_PRIO    = PC_W'(11);
    localparam logic [PC_W-1:0] S_FIN     = PC_W'(12);
    localparam logic [PC_W-1:0] S_LONG    = PC_W'(13);
    localparam logic [PC_W-1:0] S_WAKE    = PC_W'(14);
    localparam logic [PC_W-1:0] S_WLOOP   = PC_W'(15);
    localparam logic [PC_W-1:0] S_WDIV    = PC_W'(17);

    function automatic uword_t uw(input op_t o, input jc_t j, input logic [PC_W-1:0] t,
                                  input logic cl, input int cv, input logic f);
        uword_t w;
        w.op      = o;
        w.jc      = j;
        w.tgt     = t;
        w.cnt_ld  = cl;
        w.cnt_val = CNT_W'(cv);
        w.fin     = f;
        return w;
    endfunction

    function automatic uword_t rom(input logic [PC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            // periodic recompute
            PC_W'(0):  w = uw(OP_MUL_B,     JC_WAKE,   S_WAKE,    1'b0, 0,         1'b0);
            PC_W'(1):  w = uw(OP_TIMES,     JC_NONE,   S_FIN,     1'b0, 0,         1'b0);
            PC_W'(2):  w = uw(OP_MUL_PD,    JC_LONG,   S_LONG,    1'b0, 0,         1'b0);
            PC_W'(3):  w = uw(OP_TSC_LOAD,  JC_NONE,   S_FIN,     1'b1, TSC_STEPS, 1'b0);
            PC_W'(4):  w = uw(OP_DIV_STEP,  JC_LOOP,   S_DIV_TSC, 1'b0, 0,         1'b0);
            PC_W'(5):  w = uw(OP_MUL_FOLD,  JC_NONE,   S_FIN,     1'b0, 0,         1'b0);
            PC_W'(6):  w = uw(OP_ACC_ADD,   JC_NONE,   S_FIN,     1'b0, 0,         1'b0);
            PC_W'(7):  w = uw(OP_PCT_MULCB, JC_NONE,   S_FIN,     1'b0, 0,         1'b0);
            PC_W'(8):  w = uw(OP_DEC_LOAD,  JC_NONE,   S_FIN,     1'b1, DEC_STEPS, 1'b0);
            PC_W'(9):  w = uw(OP_DIV_STEP,  JC_LOOP,   S_DIV_CPU, 1'b0, 0,         1'b0);
            PC_W'(10): w = uw(OP_CPU_BIAS,  JC_NONE,   S_FIN,     1'b0, 0,         1'b0);
            PC_W'(11): w = uw(OP_PRIO,      JC_NONE,   S_FIN,     1'b0, 0,         1'b0);
            PC_W'(12): w = uw(OP_NOP,       JC_NONE,   S_FIN,     1'b0, 0,         1'b1);
            // long sleeper
            PC_W'(13): w = uw(OP_PCT_LONG,  JC_ALWAYS, S_FIN,     1'b0, 0,         1'b0);
            // wake recompute
            PC_W'(14): w = uw(OP_WAKE_INIT, JC_SHORT,  S_FIN,     1'b0, 0,         1'b0);
            PC_W'(15): w = uw(OP_MUL_CB,    JC_WDONE,  PC_W'(19), 1'b0, 0,         1'b0);
            PC_W'(16): w = uw(OP_DEC_LOAD,  JC_NONE,   S_FIN,     1'b1, DEC_STEPS, 1'b0);
            PC_W'(17): w = uw(OP_DIV_STEP,  JC_LOOP,   S_WDIV,    1'b0, 0,         1'b0);
            PC_W'(18): w = uw(OP_WAKE_NEXT, JC_ALWAYS, S_WLOOP,   1'b0, 0,         1'b0);
            PC_W'(19): w = uw(OP_WAKE_CPU,  JC_ALWAYS, S_PRIO,    1'b0, 0,         1'b0);
            default:   w = uw(OP_NOP,       JC_NONE,   S_FIN,     1'b0, 0,         1'b1);
        endcase
        return w;
    endfunction

    seq_state_t       state_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [CNT_W-1:0] cnt_reg;
    uword_t           word;
    logic             take;

    assign word = rom(pc_reg);

    always_comb begin
        case (word.jc)
            JC_NONE:   take = 1'b0;
            JC_ALWAYS: take = 1'b1;
            JC_WAKE:   take = flags.wake;
            JC_LONG:   take = flags.long_sleep;
            JC_SHORT:  take = flags.wake_short;
            JC_WDONE:  take = flags.wake_done;
            JC_LOOP:   take = (cnt_reg != CNT_W'(1));
            default:   take = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                SEQ_IDLE: begin
                    if (start) begin
                        state_reg <= SEQ_RUN;
                        pc_reg    <= '0;
                    end
                end
                SEQ_RUN: begin
                    if (word.fin) begin
                        if (out_free) begin
                            state_reg <= SEQ_IDLE;
                        end
                    end else begin
                        pc_reg <= take ? word.tgt : pc_reg + PC_W'(1);
                        if (word.cnt_ld) begin
                            cnt_reg <= word.cnt_val;
                        end else if (word.jc == JC_LOOP) begin
                            cnt_reg <= cnt_reg - CNT_W'(1);
                        end
                    end
                end
                default: state_reg <= SEQ_IDLE;
            endcase
        end
    end

    assign busy = (state_reg == SEQ_RUN);
    assign op   = busy ? word.op : OP_NOP;
    assign done = busy && word.fin && out_free;

endmodule

// ===== rtl/cudp_dp.sv =====
// Datapath: shared multiplier, bit-serial divider, accumulator and result fields.
module cudp_dp (
    input  logic             aclk,
    input  logic             load,
    input  cudp_pkg::item_t  item,
    input  cudp_pkg::cfg_t   cfg,
    input  cudp_pkg::op_t    op,
    output cudp_pkg::flags_t flags,
    output cudp_pkg::res_t   res
);
    import cudp_pkg::*;

    function automatic logic [8:0] clamp_pct(input logic signed [31:0] v);
        logic signed [31:0] sh;
        sh = v >>> FRAC_BITS;
        if (v < 0) begin
            return '0;
        end else if (sh > 32'sd511) begin
            return 9'(PCT_MAX);
        end else begin
            return sh[8:0];
        end
    endfunction

    item_t              in_reg;
    res_t               res_reg;
    logic [19:0]        b_reg;
    logic signed [30:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic [20:0]        rem_reg;
    logic [27:0]        dnd_reg;
    logic [20:0]        dsr_reg;
    logic [17:0]        quo_reg;
    logic [7:0]         a_reg;
    logic [6:0]         ws_reg;

    logic signed [9:0]  mul_a;
    logic [19:0]        mul_b;
    logic signed [30:0] mul_p;
    logic signed [9:0]  fold_f;
    logic [9:0]         hz;
    logic [21:0]        rsh;
    logic [21:0]        rsub;
    logic               ge;
    logic signed [9:0]  cpu_t;
    logic [7:0]         cpu_c;
    logic signed [10:0] nice_d;
    logic signed [10:0] fav_d;
    logic signed [10:0] prio_t;
    logic [6:0]         prio_c;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op) inside
            OP_MUL_B: begin
                mul_a = 10'(cfg.load_multiplier);
                mul_b = 20'(cfg.load_average);
            end
            OP_MUL_PD: begin
                mul_a = 10'(cfg.percent_decay);
                mul_b = 20'(in_reg.pct_cpu);
            end
            OP_MUL_FOLD: begin
                mul_a = fold_f;
                mul_b = 20'(quo_reg);
            end
            OP_PCT_MULCB, OP_MUL_CB: begin
                mul_a = 10'(a_reg);
                mul_b = b_reg;
            end
            default: ;
        endcase
    end

    assign fold_f = $signed(10'(FSCALE) - 10'(cfg.percent_decay));
    assign mul_p  = mul_a * $signed({1'b0, mul_b});
    assign hz     = (cfg.ticks_per_second == '0) ? 10'd1 : cfg.ticks_per_second;

    // one restoring divide step
    assign rsh  = {rem_reg, dnd_reg[27]};
    assign rsub = rsh - {1'b0, dsr_reg};
    assign ge   = (rsh >= {1'b0, dsr_reg});

    // usage plus nice bias, clamped
    always_comb begin
        cpu_t = $signed({2'b00, quo_reg[7:0]}) + $signed({4'b0000, in_reg.nice_value})
              - $signed({4'b0000, cfg.nice_zero});
        if (cpu_t < 0) begin
            cpu_c = '0;
        end else if (cpu_t > 10'sd255) begin
            cpu_c = 8'(CPU_MAX);
        end else begin
            cpu_c = cpu_t[7:0];
        end
    end

    // user priority from the updated usage
    always_comb begin
        nice_d = $signed({5'b00000, in_reg.nice_value}) - $signed({5'b00000, cfg.nice_zero});
        fav_d  = $signed({{5{cfg.favored_bias[5]}}, cfg.favored_bias});
        prio_t = $signed({5'b00000, res_reg.new_cpu_usage[7:2]})
               + $signed({4'b0000, cfg.user_base_priority})
               + (nice_d <<< 1);
        if (in_reg.favored) begin
            prio_t = prio_t + (fav_d <<< 1);
        end
        if (in_reg.over_rss_limit && in_reg.memory_short) begin
            prio_t = prio_t + 11'(RSS_PENALTY);
        end
        if (prio_t > 11'sd127) begin
            prio_c = 7'(PRIO_MAX);
        end else if (prio_t < 11'sd1) begin
            prio_c = 7'(PRIO_MIN);
        end else begin
            prio_c = prio_t[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_reg                 <= item;
            a_reg                  <= item.cpu_usage;
            res_reg.new_cpu_usage  <= item.cpu_usage;
            res_reg.new_pct_cpu    <= item.pct_cpu;
            res_reg.user_priority  <= '0;
            res_reg.priority_valid <= 1'b0;
            res_reg.new_run_time   <= item.run_time;
            res_reg.new_sleep_time <= item.sleep_time;
            res_reg.reschedule     <= 1'b0;
        end else begin
            unique case (op) inside
                OP_MUL_B, OP_MUL_PD, OP_MUL_FOLD, OP_MUL_CB: begin
                    prod_reg <= mul_p;
                end
                OP_TIMES: begin
                    b_reg <= prod_reg[19:0];
                    if (res_reg.new_run_time != 7'(TIME_MAX)) begin
                        res_reg.new_run_time <= res_reg.new_run_time + 7'd1;
                    end
                    if (in_reg.asleep_or_stopped
                        && res_reg.new_sleep_time != 7'(TIME_MAX)) begin
                        res_reg.new_sleep_time <= res_reg.new_sleep_time + 7'd1;
                    end
                end
                OP_TSC_LOAD: begin
                    acc_reg <= {prod_reg[30], prod_reg};
                    rem_reg <= '0;
                    dnd_reg <= {in_reg.cpu_ticks, 18'd0};
                    dsr_reg <= 21'(hz);
                    quo_reg <= '0;
                end
                OP_DIV_STEP: begin
                    rem_reg <= ge ? rsub[20:0] : rsh[20:0];
                    quo_reg <= {quo_reg[16:0], ge};
                    dnd_reg <= {dnd_reg[26:0], 1'b0};
                end
                OP_ACC_ADD: begin
                    acc_reg <= acc_reg + {prod_reg[30], prod_reg};
                end
                OP_PCT_MULCB: begin
                    res_reg.new_pct_cpu <= clamp_pct(acc_reg);
                    prod_reg            <= mul_p;
                end
                OP_DEC_LOAD: begin
                    // quotient fits 8 bits, so the top of the dividend preloads the remainder
                    rem_reg <= 21'(prod_reg[27:8]);
                    dnd_reg <= {prod_reg[7:0], 20'd0};
                    dsr_reg <= 21'(b_reg) + 21'(FSCALE);
                    quo_reg <= '0;
                end
                OP_CPU_BIAS: begin
                    res_reg.new_cpu_usage  <= cpu_c;
                    res_reg.priority_valid <= 1'b1;
                end
                OP_PRIO: begin
                    res_reg.user_priority <= prio_c;
                    res_reg.reschedule    <= (prio_c < in_reg.current_priority);
                end
                OP_PCT_LONG: begin
                    res_reg.new_pct_cpu <= clamp_pct({prod_reg[30], prod_reg});
                end
                OP_WAKE_INIT: begin
                    b_reg                  <= prod_reg[19:0];
                    res_reg.new_sleep_time <= '0;
                    ws_reg                 <= in_reg.sleep_time - 7'd2;
                end
                OP_WAKE_NEXT: begin
                    a_reg  <= quo_reg[7:0];
                    ws_reg <= ws_reg - 7'd1;
                end
                OP_WAKE_CPU: begin
                    res_reg.new_cpu_usage  <= a_reg;
                    res_reg.priority_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign flags.wake       = (in_reg.command == CMD_WAKE);
    assign flags.long_sleep = (res_reg.new_sleep_time > 7'd1);
    assign flags.wake_short = (in_reg.sleep_time <= 7'd1);
    assign flags.wake_done  = (a_reg == '0) || (ws_reg == '0);
    assign res              = res_reg;

endmodule

// ===== rtl/cudp_chk.sv =====
// Port-level checker for the decay-usage priority unit, bound to the top level.
module cudp_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_new_cpu_usage,
    input logic [8:0]  m_new_pct_cpu,
    input logic [6:0]  m_user_priority,
    input logic        m_priority_valid,
    input logic [6:0]  m_new_run_time,
    input logic [6:0]  m_new_sleep_time,
    input logic        m_reschedule
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_cpu_usage)
            && $stable(m_new_pct_cpu) && $stable(m_user_priority)
            && $stable(m_priority_valid) && $stable(m_new_run_time)
            && $stable(m_new_sleep_time) && $stable(m_reschedule))
        else $error("result changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // no recompute leaves priority and reschedule at zero
    a_noprio_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_priority_valid |-> m_user_priority == 7'd0 && !m_reschedule)
        else $error("priority fields set without recompute");

    // recomputed priority is never zero
    a_prio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_priority_valid |-> m_user_priority != 7'd0)
        else $error("recomputed priority out of range");

endmodule

bind cpu_usage_decay_priority cudp_chk u_cudp_chk (.*);
